[src/slrm_pkg.sv]
// ----------------------------------------------------------------------------
// slrm_pkg
// Shared types and constants of the stereo resampler and mixer.
// ----------------------------------------------------------------------------
package slrm_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SAMPLE_W      = 16;
	localparam int LANES         = 4;   // inst l, inst r, voice l, voice r
	localparam int CNT_W         = 3;   // results per frame, 0 to 4
	localparam int CFG_IDX_W     = 1;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RATE             = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE_MIX_ENABLE = 1'd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] inst_left;
		logic signed [SAMPLE_W-1:0] inst_right;
		logic signed [SAMPLE_W-1:0] voice_left;
		logic signed [SAMPLE_W-1:0] voice_right;
		logic                       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
		logic                       last_of_run;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // take a new frame
		logic mul;     // form products for one output position, advance position
		logic mix;     // finish the sample into the output register
		logic adjust;  // consume one source frame from the position
		logic commit;  // update the held frame and stored position
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;          // another output position is due
		logic phase_interp;  // still between held and current frame
		logic out_busy;      // output register occupied and not taken
	} dp_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MIX
	} state_t;

endpackage

[src/slrm_stream_if.sv]
// ----------------------------------------------------------------------------
// slrm_stream_if
// Valid/ready channel carrying one item per transfer.
// ----------------------------------------------------------------------------
interface slrm_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[src/slrm_ctrl.sv]
// ----------------------------------------------------------------------------
// slrm_ctrl
// Sequencer for frame intake, per-position products, mixing and commit.
// ----------------------------------------------------------------------------
module slrm_ctrl import slrm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.emit) begin
					cmd.mul = 1'b1;
					state_d = ST_MIX;
				end else if (status.phase_interp) begin
					cmd.adjust = 1'b1;
				end else begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MIX: begin
				// wait while the previous sample still sits in the output register
				if (!status.out_busy) begin
					cmd.mix = 1'b1;
					state_d = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/slrm_dp.sv]
// ----------------------------------------------------------------------------
// slrm_dp
// Frame store, read position, interpolation products and saturating mix.
// ----------------------------------------------------------------------------
module slrm_dp import slrm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_status_t             status,
	input  logic                   cfg_write,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [FRAC_BITS+1:0]   cfg_data,
	input  in_item_t               in_item,
	output out_item_t              out_item,
	output logic                   out_valid,
	input  logic                   out_ready
);

	localparam int PosW  = FRAC_BITS + 2;
	localparam int DiffW = SAMPLE_W + 1;
	localparam int ProdW = DiffW + FRAC_BITS + 1;

	localparam logic [PosW-1:0]  PosOne   = PosW'(1) << FRAC_BITS;
	localparam logic [PosW-1:0]  RateMin  = PosOne >> 1;
	localparam logic [PosW-1:0]  RateMax  = PosW'(3) << FRAC_BITS;
	localparam logic [CNT_W-1:0] InterpMx = CNT_W'(2);
	localparam logic [CNT_W-1:0] TotalMx  = CNT_W'(4);

	logic signed [SAMPLE_W-1:0] held_q [LANES];
	logic signed [SAMPLE_W-1:0] cur_q  [LANES];
	logic                       last_q;
	logic [PosW-1:0]            pos_q;
	logic [PosW-1:0]            rd_pos_q;
	logic                       have_prev_q;
	logic                       phase_interp_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [PosW-1:0]            rate_q;
	logic                       voice_en_q;

	logic signed [ProdW-1:0]    prod_s1 [LANES];
	logic signed [SAMPLE_W-1:0] base_s1 [LANES];

	out_item_t                  out_q;
	logic                       out_valid_q;

	logic signed [DiffW-1:0]     diff   [LANES];
	logic signed [ProdW-1:0]     prod_d [LANES];
	logic signed [FRAC_BITS:0]   frac_s;
	logic signed [SAMPLE_W-1:0]  lane_v [LANES];
	logic signed [SAMPLE_W-1:0]  mix_l;
	logic signed [SAMPLE_W-1:0]  mix_r;
	logic [PosW-1:0]             pos_adj;
	logic                        more;
	logic [PosW-1:0]             rate_clamped;

	// a + floor(prod / 2^FRAC_BITS)
	function automatic logic signed [SAMPLE_W-1:0] interp_fin(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [ProdW-1:0]    p
	);
		logic signed [ProdW-1:0]  q_wide;
		logic signed [DiffW-1:0]  q;
		logic signed [DiffW-1:0]  s;
		q_wide = p >>> FRAC_BITS;
		q      = q_wide[DiffW-1:0];
		s      = {a[SAMPLE_W-1], a} + q;
		return s[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_add(
		input logic signed [SAMPLE_W-1:0] x,
		input logic signed [SAMPLE_W-1:0] y
	);
		logic signed [SAMPLE_W:0] s;
		s = {x[SAMPLE_W-1], x} + {y[SAMPLE_W-1], y};
		if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
			return s[SAMPLE_W] ? SAT_MIN : SAT_MAX;
		end
		return s[SAMPLE_W-1:0];
	endfunction

	// products for the current position
	assign frac_s = {1'b0, pos_q[FRAC_BITS-1:0]};

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (phase_interp_q) begin
				diff[i] = {cur_q[i][SAMPLE_W-1], cur_q[i]} - {held_q[i][SAMPLE_W-1], held_q[i]};
			end else begin
				diff[i] = '0;
			end
			prod_d[i] = diff[i] * frac_s;
		end
	end

	// interpolate and mix
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_v[i] = interp_fin(base_s1[i], prod_s1[i]);
		end
		if (!voice_en_q) begin
			lane_v[2] = '0;
			lane_v[3] = '0;
		end
		mix_l = sat_add(lane_v[0], lane_v[2]);
		mix_r = sat_add(lane_v[1], lane_v[3]);
	end

	// position control
	assign pos_adj = (pos_q >= PosOne) ? pos_q - PosOne : '0;

	always_comb begin
		if (phase_interp_q) begin
			status.emit = (pos_q < PosOne) && (cnt_q < InterpMx);
			more        = ((pos_q < PosOne) && (cnt_q < InterpMx)) ||
			              (last_q && (pos_adj < PosOne) && (cnt_q < TotalMx));
		end else begin
			status.emit = last_q && (pos_q < PosOne) && (cnt_q < TotalMx);
			more        = status.emit;
		end
		status.phase_interp = phase_interp_q;
		status.out_busy     = out_valid_q && !out_ready;
	end

	always_comb begin
		rate_clamped = cfg_data;
		if (cfg_data < RateMin) begin
			rate_clamped = RateMin;
		end else if (cfg_data > RateMax) begin
			rate_clamped = RateMax;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= PosOne;
			voice_en_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RATE:             rate_q     <= rate_clamped;
				REG_VOICE_MIX_ENABLE: voice_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// frame state and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				held_q[i] <= '0;
			end
			rd_pos_q       <= '0;
			have_prev_q    <= 1'b0;
			pos_q          <= '0;
			cnt_q          <= '0;
			phase_interp_q <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			if (cmd.load) begin
				pos_q          <= rd_pos_q;
				cnt_q          <= '0;
				phase_interp_q <= have_prev_q;
				last_q         <= in_item.end_of_stream;
			end
			if (cmd.mul) begin
				pos_q <= pos_q + rate_q;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.adjust) begin
				pos_q          <= pos_adj;
				phase_interp_q <= 1'b0;
			end
			if (cmd.commit) begin
				for (int i = 0; i < LANES; i++) begin
					held_q[i] <= last_q ? '0 : cur_q[i];
				end
				rd_pos_q    <= last_q ? '0 : pos_q;
				have_prev_q <= !last_q;
			end
		end
	end

	// current frame, products and output data
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q[0] <= in_item.inst_left;
			cur_q[1] <= in_item.inst_right;
			cur_q[2] <= in_item.voice_left;
			cur_q[3] <= in_item.voice_right;
		end
		if (cmd.mul) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s1[i] <= prod_d[i];
				base_s1[i] <= phase_interp_q ? held_q[i] : cur_q[i];
			end
		end
		if (cmd.mix) begin
			out_q.out_left    <= mix_l;
			out_q.out_right   <= mix_r;
			out_q.last_of_run <= !more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.mix) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_item  = out_q;
	assign out_valid = out_valid_q;

endmodule

[src/stereo_linear_resampler_mixer.sv]
// ----------------------------------------------------------------------------
// stereo_linear_resampler_mixer
// Linear-interpolation sample rate converter with instrument and voice mix.
// ----------------------------------------------------------------------------
// Each source frame transfer carries an instrument and a voice stereo pair.
// The block keeps the previous frame and a read position with FRAC_BITS
// fraction bits; every output position between the previous and current
// frame gives one sample, the instrument pair interpolated and the voice
// pair (when voice mixing is on) added with saturation to 16 bits. A frame
// gives zero to two interpolated samples, and the final frame (end_of_stream)
// repeats its own value for positions that fall inside it, up to four samples
// in all, after which the block returns to its reset state (registers kept).
// last_of_run marks the final sample of each frame. Frames are handled one at
// a time: the sequencer takes the frame, runs a multiply and a mix step per
// sample, consumes one source frame from the position when a previous frame
// exists, and commits; a sample still waiting in the output register holds
// the next mix step. Rate register writes are clamped to 0.5..3.0.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_mixer import slrm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	slrm_stream_if.sink          frames,
	slrm_stream_if.source        samples,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAC_BITS+1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready;

	// sequencer: frame intake, per-sample steps, commit
	slrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frames.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: held frame, position, products, mix and output register
	slrm_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (frames.data),
		.out_item  (samples.data),
		.out_valid (samples.valid),
		.out_ready (samples.ready)
	);

	assign frames.ready = in_ready;

	// a mix step never overwrites a sample that has not been transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix |-> !(samples.valid && !samples.ready))
		else $error("output sample overwritten before transfer");

	// a frame transfer happens only while no sample step runs
	a_intake_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(frames.valid && frames.ready) |-> !(cmd.mul || cmd.mix || cmd.commit))
		else $error("frame taken during sample processing");

	// every mix step shows a sample in the next cycle
	a_mix_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix |=> samples.valid)
		else $error("mixed sample not presented");

	// each multiply step is followed by its mix step before any other work
	a_mul_then_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> !(cmd.mul || cmd.adjust || cmd.commit || cmd.load))
		else $error("multiply step not followed by mix");

endmodule
